// ===== rtl/sopf_pkg.sv =====
package sopf_pkg;

  // Default number of table entries.
  localparam int DEF_TABLE_DEPTH = 32;

  // Port widths.
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int MASK_W      = 32;
  localparam int HCNT_W      = 6;
  localparam int SPHERE_W    = 63;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_STORE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_QSTORE = 2'd3
  } op_t;

  // One sphere as packed on in_tdata: x in the lowest bits, radius on top.
  typedef struct packed {
    logic [14:0] radius;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } sphere_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch the accepted item
    logic scan_en;  // read one stored entry into the distance pipeline
    logic commit;   // store, update the table and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_entries;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } status_t;

  function automatic logic op_queries(input op_t op);
    return (op == OP_QUERY) || (op == OP_QSTORE);
  endfunction

  function automatic logic op_stores(input op_t op);
    return (op == OP_STORE) || (op == OP_QSTORE);
  endfunction

endpackage

// ===== rtl/sopf_ctrl.sv =====
module sopf_ctrl
  import sopf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  op_t     in_op,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (op_queries(in_op) && status.has_entries) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/sopf_dp.sv =====
module sopf_dp
  import sopf_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  op_t                    in_op,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int MSEL_W = $clog2(MASK_W);

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] d;
    logic [16:0] n;
    d = {a[15], a} - {b[15], b};
    n = -d;
    return d[16] ? n[15:0] : d[15:0];
  endfunction

  sphere_t mem [TABLE_DEPTH];

  sphere_t              q_r;
  op_t                  op_r;
  logic [CNT_W-1:0]     entry_count_r;
  logic [ADDR_W-1:0]    scan_addr_r;

  // Distance pipeline: read, differences, squares, compare.
  sphere_t              rd_r;
  logic                 v0_r, v1_r, v2_r, v3_r;
  logic [ADDR_W-1:0]    idx0_r, idx1_r, idx2_r, idx3_r;
  logic [15:0]          adx_r, ady_r, adz_r, rsum_r;
  logic [31:0]          sqx_r, sqy_r, sqz_r, rsq_r;
  logic                 hit_r;

  logic [MASK_W-1:0]    mask_r;
  logic [HCNT_W-1:0]    hcnt_r;
  logic                 out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                 table_full;
  logic                 store_ok;
  logic [33:0]          dist_sum;
  logic [31:0]          idx_ext;

  assign table_full = (entry_count_r == CNT_W'(TABLE_DEPTH));
  assign store_ok   = op_stores(op_r) && !table_full;
  assign dist_sum   = 34'(sqx_r) + 34'(sqy_r) + 34'(sqz_r);
  assign idx_ext    = 32'(idx3_r);

  assign status.has_entries = (entry_count_r != '0);
  assign status.scan_last   = ((CNT_W'(scan_addr_r) + CNT_W'(1)) == entry_count_r);
  assign status.pipe_busy   = v0_r | v1_r | v2_r | v3_r;
  assign status.out_free    = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.commit && store_ok) begin
      mem[entry_count_r[ADDR_W-1:0]] <= q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      rd_r <= mem[scan_addr_r];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      scan_addr_r   <= '0;
      v0_r          <= 1'b0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      v0_r <= cmd.scan_en;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.load) begin
        scan_addr_r <= '0;
      end else if (cmd.scan_en) begin
        scan_addr_r <= scan_addr_r + ADDR_W'(1);
      end
      if (cmd.commit) begin
        if (op_r == OP_CLEAR) begin
          entry_count_r <= '0;
        end else if (store_ok) begin
          entry_count_r <= entry_count_r + CNT_W'(1);
        end
      end
      if (cmd.commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r  <= sphere_t'(in_tdata[SPHERE_W-1:0]);
      op_r <= in_op;
    end
    idx0_r <= scan_addr_r;
    idx1_r <= idx0_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    adx_r  <= abs_diff(q_r.x, rd_r.x);
    ady_r  <= abs_diff(q_r.y, rd_r.y);
    adz_r  <= abs_diff(q_r.z, rd_r.z);
    rsum_r <= 16'(q_r.radius) + 16'(rd_r.radius);
    sqx_r  <= adx_r * adx_r;
    sqy_r  <= ady_r * ady_r;
    sqz_r  <= adz_r * adz_r;
    rsq_r  <= rsum_r * rsum_r;
    hit_r  <= (dist_sum <= 34'(rsq_r));
    if (cmd.load) begin
      mask_r <= '0;
      hcnt_r <= '0;
    end else if (v3_r && hit_r) begin
      if (idx_ext < MASK_W) begin
        mask_r[idx_ext[MSEL_W-1:0]] <= 1'b1;
      end
      if (hcnt_r != '1) begin
        hcnt_r <= hcnt_r + HCNT_W'(1);
      end
    end
    if (cmd.commit) begin
      out_tdata_r <= OUT_TDATA_W'({op_stores(op_r) && table_full, hcnt_r, mask_r});
    end
  end

endmodule

// ===== rtl/sphere_overlap_pair_finder_top.sv =====
// Sphere overlap finder: keeps a table of spheres and tests new spheres
// against every stored one.
//
// Input channel (in_*): one beat per item. in_tuser carries the op (clear,
// store, query, query then store); in_tdata carries the sphere centre and
// radius. Every accepted beat produces exactly one result beat on out_*,
// carrying the hit mask over the stored entries, the hit count and a flag
// that marks a store dropped because the table was full.
//
// The block works on one item at a time. A query scans the stored entries
// through the single shared distance pipeline, which reads one entry per
// cycle, then lets the pipeline drain and commits. Clear, store and queries
// on an empty table go straight to the commit. A new item is accepted in
// the cycle after the commit.
//
// Reset empties the table; no clearing pass is needed. When the receiver
// stalls, the result waits in the output register and a new item may still
// be accepted and worked on; it holds in its final step until the output
// register is free.
module sphere_overlap_pair_finder_top
  import sopf_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pos_x [15:0], pos_y [31:16], pos_z [47:32], radius [62:48], zero [63]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op [1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // hit_mask [31:0], hit_count [37:32], table_full [38], zero [39]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cmd_t    cmd;
  status_t status;
  op_t     in_op;

  assign in_op = op_t'(in_tuser);

  // The controller sequences each item: accept; for a query with stored
  // entries, scan them and drain the pipeline; then commit store and result.
  sopf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_op),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the table memory, the distance pipeline, the hit
  // accumulators and the output register.
  sopf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_op      (in_op),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Only one item is in flight, so an accepted beat closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // The hit count can never fall below the number of mask bits set.
  a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[37:32] >= 6'($countones(out_tdata[31:0]))))
    else $error("hit count below mask population");

  // A result is only committed from the final step of an item.
  a_commit_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !status.pipe_busy && !cmd.scan_en)
    else $error("commit while the distance pipeline is busy");

endmodule
